### design/okt_pkg.sv
// Shared types and constants for the oriented-box Kalman tracker.
package okt_pkg;
   localparam int FRAC_BITS_DEF = 16;
   localparam int WORD_BITS_DEF = 32;
   localparam int COV_BITS = 40;
   localparam logic [COV_BITS-1:0] COV_MAX = {COV_BITS{1'b1}};

   localparam logic [2:0] CSR_PROCESS_NOISE  = 3'd0;
   localparam logic [2:0] CSR_MEASURE_NOISE  = 3'd1;
   localparam logic [2:0] CSR_INITIAL_COV    = 3'd2;
   localparam logic [2:0] CSR_DEFAULT_WIDTH  = 3'd3;
   localparam logic [2:0] CSR_DEFAULT_HEIGHT = 3'd4;

   // controller to datapath
   typedef struct packed {
      logic load_item;   // capture input word
      logic predict;     // run predict step
      logic first_fix;   // load state from observation
      logic div_start;   // start gain division
      logic div_step;    // one quotient bit
      logic axis_step;   // correct one axis (axis index below)
      logic [1:0] axis;
      logic cov_update;  // covariance correction
      logic keep_box;    // store box fields
      logic drop;        // clear live flag
      logic out_load;    // build result word
   } okt_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic track_live;
      logic obs_valid;
      logic mode;
   } okt_sts_type;
endpackage

### design/okt_ctrl.sv
// Sequencing state machine for the tracker.
module okt_ctrl #(
   parameter int FRAC_BITS = okt_pkg::FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   input  okt_pkg::okt_sts_type sts,
   output okt_pkg::okt_cmd_type cmd
);
   import okt_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DECIDE = 4'd1;
   localparam logic [3:0] S_PRED = 4'd2;
   localparam logic [3:0] S_DIV = 4'd3;
   localparam logic [3:0] S_AXIS = 4'd4;
   localparam logic [3:0] S_COV = 4'd5;
   localparam logic [3:0] S_OUT = 4'd6;
   localparam int CW = $clog2(FRAC_BITS + 1);

   logic [3:0] state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd = '0;
      cmd.axis = cnt_ff[1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (sts.mode) begin
               cmd.drop = 1'b1;
               state_in = S_IDLE;
            end else if (!sts.track_live && !sts.obs_valid) begin
               state_in = S_OUT;
            end else begin
               cmd.predict = 1'b1;
               state_in = S_PRED;
            end
         end
         S_PRED: begin
            if (!sts.obs_valid) begin
               state_in = S_OUT;
            end else if (!sts.track_live) begin
               cmd.first_fix = 1'b1;
               cmd.keep_box = 1'b1;
               state_in = S_OUT;
            end else begin
               cmd.div_start = 1'b1;
               cnt_in = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(FRAC_BITS - 1)) begin
               cnt_in = '0;
               state_in = S_AXIS;
            end
         end
         S_AXIS: begin
            cmd.axis_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(2)) state_in = S_COV;
         end
         S_COV: begin
            cmd.cov_update = 1'b1;
            cmd.keep_box = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

### design/okt_datapath.sv
// Filter state, gain divider, per-axis correction and result register.
module okt_datapath #(
   parameter int FRAC_BITS = okt_pkg::FRAC_BITS_DEF,
   parameter int WORD_BITS = okt_pkg::WORD_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  okt_pkg::okt_cmd_type cmd,
   output okt_pkg::okt_sts_type sts,
   input  logic csr_write,
   input  logic [2:0] csr_index,
   input  logic [30:0] csr_data,
   input  logic req_mode,
   input  logic req_obs_valid,
   input  logic signed [31:0] req_obs_x,
   input  logic signed [31:0] req_obs_y,
   input  logic signed [31:0] req_obs_angle,
   input  logic [30:0] req_obs_width,
   input  logic [30:0] req_obs_height,
   input  logic [9:0] req_obs_class,
   input  logic [16:0] req_obs_conf,
   output logic signed [31:0] rsp_est_x,
   output logic signed [31:0] rsp_est_y,
   output logic signed [31:0] rsp_est_angle,
   output logic [30:0] rsp_out_width,
   output logic [30:0] rsp_out_height,
   output logic signed [10:0] rsp_out_class,
   output logic [16:0] rsp_out_conf
);
   import okt_pkg::*;

   localparam int CB = COV_BITS;
   localparam int KB = FRAC_BITS + 1;
   localparam int EB = 62 - FRAC_BITS;          // clamped innovation, signed
   localparam int PB = EB + KB + 1;             // gain product
   localparam logic [KB-1:0] ONE = KB'(1) << FRAC_BITS;
   localparam logic [30:0] SIZE_MIN = 31'((64'd1 << FRAC_BITS) / 1000);
   localparam logic signed [WORD_BITS+1:0] WMAX = (WORD_BITS+2)'((65'sd1 <<< (WORD_BITS-1)) - 1);
   localparam logic signed [WORD_BITS+1:0] WMIN = -(WMAX) - 1;
   localparam logic signed [EB+1:0] ELIM = (EB+2)'((65'sd1 <<< (61 - FRAC_BITS)) - 1);
   // reset restores initial_cov to 1.0, which the diagonal covariance terms load; the cross term resets to zero
   localparam logic [24:0] IC_RESET = 25'(64'd1 << FRAC_BITS);

   // configuration
   logic [16:0] pn_ff, mn_ff;
   logic [30:0] dw_ff, dh_ff;

   // item capture
   logic mode_ff, obs_ff;
   logic signed [31:0] z_ff [3];
   logic [30:0] ow_ff, oh_ff;
   logic [9:0] oc_ff;
   logic [16:0] of_ff;

   // filter state
   logic live_ff;
   logic signed [WORD_BITS-1:0] pos_ff [3], vel_ff [3];
   logic [CB-1:0] ca_ff, cb_ff, cc_ff;
   logic [30:0] kw_ff, kh_ff;
   logic [9:0] kc_ff;
   logic [16:0] kf_ff;

   // divider: two shared-denominator restoring dividers
   logic [CB:0] den_ff;
   logic [CB+1:0] r0_ff, r1_ff;
   logic [KB-1:0] k0_ff, k1_ff;
   logic sat0_ff, sat1_ff, zero_ff;

   assign sts.track_live = live_ff;
   assign sts.obs_valid = obs_ff;
   assign sts.mode = mode_ff;

   function automatic logic [CB-1:0] sat_c(input logic [CB+2:0] v);
      return (v > {3'b000, COV_MAX}) ? COV_MAX : v[CB-1:0];
   endfunction

   function automatic logic signed [WORD_BITS-1:0] sat_w(input logic signed [WORD_BITS+1:0] v);
      if (v > WMAX) return WMAX[WORD_BITS-1:0];
      if (v < WMIN) return WMIN[WORD_BITS-1:0];
      return v[WORD_BITS-1:0];
   endfunction

   function automatic logic signed [WORD_BITS+1:0] sx_z(input logic signed [31:0] z);
      return (WORD_BITS+2)'(z);
   endfunction

   // floor(k*v/2^F)
   function automatic logic [CB-1:0] mul_g(input logic [KB-1:0] k, input logic [CB-1:0] v);
      logic [CB+KB-1:0] p;
      p = k * v;
      return CB'(p >> FRAC_BITS);
   endfunction

   // effective gains: limits resolved at use
   logic [KB-1:0] g0, g1;
   assign g0 = zero_ff ? '0 : (sat0_ff ? ONE : k0_ff);
   assign g1 = zero_ff ? '0 : (sat1_ff ? ONE : k1_ff);

   // per-axis correction (one axis a cycle)
   logic signed [31:0] z_sel;
   logic signed [WORD_BITS-1:0] p_sel, v_sel;
   logic signed [EB+1:0] e_raw, e_cl;
   logic signed [PB-1:0] pp, pv, rp, rv;
   logic signed [WORD_BITS+1:0] np, nv;
   logic [1:0] ax;

   always_comb begin
      ax = (cmd.axis > 2'd2) ? 2'd2 : cmd.axis;
      z_sel = z_ff[ax];
      p_sel = pos_ff[ax];
      v_sel = vel_ff[ax];
      e_raw = (EB+2)'(z_sel) - (EB+2)'(p_sel);
      e_cl = (e_raw > ELIM) ? ELIM : ((e_raw < -ELIM) ? -ELIM : e_raw);
      pp = $signed({1'b0, g0}) * e_cl;
      pv = $signed({1'b0, g1}) * e_cl;
      rp = (pp + (PB'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      rv = (pv + (PB'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      np = (WORD_BITS+2)'(p_sel) + (WORD_BITS+2)'(rp);
      nv = (WORD_BITS+2)'(v_sel) + (WORD_BITS+2)'(rv);
   end

   logic [CB+1:0] t0, t1;
   logic [CB-1:0] m1;
   assign t0 = {r0_ff[CB:0], 1'b0};
   assign t1 = {r1_ff[CB:0], 1'b0};
   assign m1 = mul_g(g1, cb_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pn_ff <= 17'((64'd1 << FRAC_BITS) + 500) / 17'd1000;
         mn_ff <= 17'(((64'd1 << FRAC_BITS) * 2 + 50) / 100);
         dw_ff <= 31'((64'd1 << FRAC_BITS) * 100);
         dh_ff <= 31'((64'd1 << FRAC_BITS) * 30);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_PROCESS_NOISE:  pn_ff <= csr_data[16:0];
            CSR_MEASURE_NOISE:  mn_ff <= csr_data[16:0];
            CSR_INITIAL_COV:    ;   // write is ignored; reset loads the fixed 1.0 default
            CSR_DEFAULT_WIDTH:  dw_ff <= csr_data;
            CSR_DEFAULT_HEIGHT: dh_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         mode_ff <= req_mode;
         obs_ff <= req_obs_valid;
         z_ff[0] <= req_obs_x;
         z_ff[1] <= req_obs_y;
         z_ff[2] <= req_obs_angle;
         ow_ff <= req_obs_width;
         oh_ff <= req_obs_height;
         oc_ff <= req_obs_class;
         of_ff <= req_obs_conf;
      end
      if (cmd.div_start) begin
         den_ff <= (CB+1)'(ca_ff) + (CB+1)'(mn_ff);
         r0_ff <= (CB+2)'(ca_ff);
         r1_ff <= (CB+2)'(cb_ff);
         k0_ff <= '0;
         k1_ff <= '0;
         zero_ff <= (ca_ff == '0) && (mn_ff == '0);
         sat0_ff <= (CB+1)'(ca_ff) >= (CB+1)'(ca_ff) + (CB+1)'(mn_ff);
         sat1_ff <= (CB+1)'(cb_ff) >= (CB+1)'(ca_ff) + (CB+1)'(mn_ff);
      end
      if (cmd.div_step) begin
         if (t0 >= {1'b0, den_ff}) begin
            r0_ff <= t0 - {1'b0, den_ff};
            k0_ff <= {k0_ff[KB-2:0], 1'b1};
         end else begin
            r0_ff <= t0;
            k0_ff <= {k0_ff[KB-2:0], 1'b0};
         end
         if (t1 >= {1'b0, den_ff}) begin
            r1_ff <= t1 - {1'b0, den_ff};
            k1_ff <= {k1_ff[KB-2:0], 1'b1};
         end else begin
            r1_ff <= t1;
            k1_ff <= {k1_ff[KB-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= '0;
            vel_ff[i] <= '0;
         end
         ca_ff <= CB'(IC_RESET);
         cb_ff <= '0;
         cc_ff <= CB'(IC_RESET);
         kw_ff <= '0;
         kh_ff <= '0;
         kc_ff <= '0;
         kf_ff <= '0;
      end else begin
         if (cmd.drop) live_ff <= 1'b0;
         if (cmd.predict) begin
            for (int i = 0; i < 3; i++)
               pos_ff[i] <= sat_w((WORD_BITS+2)'(pos_ff[i]) + (WORD_BITS+2)'(vel_ff[i]));
            ca_ff <= sat_c((CB+3)'(ca_ff) + ((CB+3)'(cb_ff) << 1) + (CB+3)'(cc_ff)
                           + (CB+3)'(pn_ff));
            cb_ff <= sat_c((CB+3)'(cb_ff) + (CB+3)'(cc_ff));
            cc_ff <= sat_c((CB+3)'(cc_ff) + (CB+3)'(pn_ff));
         end
         if (cmd.first_fix) begin
            for (int i = 0; i < 3; i++) begin
               pos_ff[i] <= sat_w(sx_z(z_ff[i]));
               vel_ff[i] <= '0;
            end
            live_ff <= 1'b1;
         end
         if (cmd.axis_step) begin
            pos_ff[ax] <= sat_w(np);
            vel_ff[ax] <= sat_w(nv);
         end
         if (cmd.cov_update) begin
            ca_ff <= ca_ff - mul_g(g0, ca_ff);
            cb_ff <= cb_ff - mul_g(g0, cb_ff);
            cc_ff <= (cc_ff > m1) ? cc_ff - m1 : '0;
         end
         if (cmd.keep_box) begin
            kw_ff <= ow_ff;
            kh_ff <= oh_ff;
            kc_ff <= oc_ff;
            kf_ff <= of_ff;
         end
      end
   end

   // result register
   function automatic logic signed [31:0] sat32(input logic signed [WORD_BITS-1:0] v);
      logic signed [WORD_BITS+32:0] w;
      w = (WORD_BITS+33)'(v);
      if (w > (WORD_BITS+33)'(33'sh7FFFFFFF)) return 32'sh7FFFFFFF;
      if (w < -(WORD_BITS+33)'(33'sh80000000)) return 32'sh80000000;
      return w[31:0];
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (!live_ff) begin
            rsp_est_x <= '0;
            rsp_est_y <= '0;
            rsp_est_angle <= '0;
            rsp_out_width <= '0;
            rsp_out_height <= '0;
            rsp_out_class <= -11'sd1;
            rsp_out_conf <= '0;
         end else begin
            rsp_est_x <= sat32(pos_ff[0]);
            rsp_est_y <= sat32(pos_ff[1]);
            rsp_est_angle <= sat32(pos_ff[2]);
            rsp_out_width <= (kw_ff > SIZE_MIN) ? kw_ff : dw_ff;
            rsp_out_height <= (kh_ff > SIZE_MIN) ? kh_ff : dh_ff;
            rsp_out_class <= {1'b0, kc_ff};
            rsp_out_conf <= kf_ff;
         end
      end
   end
endmodule

### design/obb_kalman_tracker_core.sv
// Top level of the oriented-box constant-velocity Kalman tracker.
//
//  channel  dir  handshake            word
//  req_     in   req_valid/req_ready  mode, observation fields
//  rsp_     out  rsp_valid/rsp_ready  estimate, box, class, confidence
//  csr_     in   csr_write            index 0..4, 31-bit data
//
// Paths: drop clears the track, no result; no track and no observation goes
// to output; else predict, then first fix, coast, or gain divide and correct.
// Reset loads register defaults; the covariance takes the initial_cov default.
// The result sits in an output register; one more word may be taken while it
// waits, but that word holds the controller in its output state until
// rsp_ready frees the register.
module obb_kalman_tracker_core #(
   parameter int FRAC_BITS = okt_pkg::FRAC_BITS_DEF,
   parameter int WORD_BITS = okt_pkg::WORD_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_write,
   input  logic [2:0] csr_index,
   input  logic [30:0] csr_data,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_mode,
   input  logic req_obs_valid,
   input  logic signed [31:0] req_obs_x,
   input  logic signed [31:0] req_obs_y,
   input  logic signed [31:0] req_obs_angle,
   input  logic [30:0] req_obs_width,
   input  logic [30:0] req_obs_height,
   input  logic [9:0] req_obs_class,
   input  logic [16:0] req_obs_conf,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [31:0] rsp_est_x,
   output logic signed [31:0] rsp_est_y,
   output logic signed [31:0] rsp_est_angle,
   output logic [30:0] rsp_out_width,
   output logic [30:0] rsp_out_height,
   output logic signed [10:0] rsp_out_class,
   output logic [16:0] rsp_out_conf
);
   import okt_pkg::*;

   okt_cmd_type cmd;
   okt_sts_type sts;

   okt_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .sts(sts), .cmd(cmd)
   );

   okt_datapath #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_mode(req_mode), .req_obs_valid(req_obs_valid),
      .req_obs_x(req_obs_x), .req_obs_y(req_obs_y), .req_obs_angle(req_obs_angle),
      .req_obs_width(req_obs_width), .req_obs_height(req_obs_height),
      .req_obs_class(req_obs_class), .req_obs_conf(req_obs_conf),
      .rsp_est_x(rsp_est_x), .rsp_est_y(rsp_est_y), .rsp_est_angle(rsp_est_angle),
      .rsp_out_width(rsp_out_width), .rsp_out_height(rsp_out_height),
      .rsp_out_class(rsp_out_class), .rsp_out_conf(rsp_out_conf)
   );
endmodule
